// ===== src/tfd_pkg.sv =====
// Shared result kinds, frame constants and field widths for the touch frame decoder.
package tfd_pkg;

    localparam int KindWidth = 3;
    localparam int CoordWidth = 12;

    typedef logic [KindWidth-1:0] kind_t;
    typedef logic [CoordWidth-1:0] coord_t;

    localparam kind_t KIND_TOUCH = 3'd0;
    localparam kind_t KIND_SKIPPED = 3'd1;
    localparam kind_t KIND_RESP_OK = 3'd2;
    localparam kind_t KIND_RESP_ERR = 3'd3;
    localparam kind_t KIND_UNKNOWN = 3'd4;

    localparam logic [7:0] HDR_RESPONSE = 8'h55;

    localparam logic [7:0] CMD_CODE_12 = 8'h12;
    localparam logic [7:0] CMD_CODE_13 = 8'h13;
    localparam logic [7:0] CMD_CODE_20 = 8'h20;
    localparam logic [7:0] CMD_CODE_21 = 8'h21;

    localparam logic [7:0] RESP_LEN_NO_DATA = 8'h02;
    localparam logic [7:0] RESP_LEN_ONE_BYTE = 8'h03;

    localparam logic [7:0] PRESSURE_DOWN = 8'hFF;

    // Output tdata layout, lowest bit first.
    localparam int OutDataWidth = 56;
    localparam int OutUsedWidth = 50;

endpackage

// ===== src/touch_frame_decoder.sv =====
// Touch frame decoder: one five-byte controller frame in, one decoded result out.
// The result is registered: it appears on the master side in the cycle after its frame beat is accepted.
// One frame per cycle while the master side is not stalled; the result register is reloaded in the cycle it is taken.
// The pen and skip-counter state updates on each accepted touch beat, in arrival order.
// Reset (rst_n low, asynchronous) clears the result valid, the skip setting,
// the previous pen bit and the skip counter.
module touch_frame_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration: skip_count
    input  logic                          cfg_wr_en,
    input  logic [7:0]                    cfg_wr_data,
    // Frame input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // expected_command, frame_byte0, frame_byte1, frame_byte2, frame_byte3, frame_byte4
    input  logic [47:0]                   s_axis_tdata,
    // command_pending
    input  logic [0:0]                    s_axis_tuser,
    // Result output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pen_contact, position_x, position_y, pressure, response_command,
    // response_length, response_data, zero fill
    output logic [tfd_pkg::OutDataWidth-1:0] m_axis_tdata,
    // result_kind
    output tfd_pkg::kind_t                m_axis_tuser
);
    import tfd_pkg::*;

    logic       pending;
    logic [7:0] cmd;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;

    logic [7:0] skip_count_reg;
    logic       prev_pen_reg;
    logic       prev_pen_next;
    logic [7:0] skip_rem_reg;
    logic [7:0] skip_rem_next;

    logic       m_valid_reg;
    kind_t      kind_reg;
    kind_t      kind_next;
    logic [tfd_pkg::OutDataWidth-1:0] data_reg;
    logic [tfd_pkg::OutDataWidth-1:0] data_next;

    logic       accept;
    logic       is_touch;
    logic       is_resp;
    logic       pen;
    coord_t     pos_x;
    coord_t     pos_y;
    logic       len_ok;
    logic       resp_good;
    logic       resp_len;

    assign pending = s_axis_tuser[0];
    assign cmd = s_axis_tdata[7:0];
    assign b0 = s_axis_tdata[15:8];
    assign b1 = s_axis_tdata[23:16];
    assign b2 = s_axis_tdata[31:24];
    assign b3 = s_axis_tdata[39:32];
    assign b4 = s_axis_tdata[47:40];

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;

    assign is_touch = !pending && b0[7];
    assign is_resp = pending && (b0 == HDR_RESPONSE);
    assign pen = b0[0];
    assign pos_x = {b2[4:0], b1[6:0]};
    assign pos_y = {b4[4:0], b3[6:0]};

    always_comb
    begin
        unique case (cmd)
            CMD_CODE_12, CMD_CODE_13, CMD_CODE_21: len_ok = (b1 == RESP_LEN_NO_DATA);
            CMD_CODE_20:                           len_ok = (b1 == RESP_LEN_ONE_BYTE);
            default:                               len_ok = 1'b0;
        endcase
    end

    assign resp_good = (b2 == 8'h00) && (b3 == cmd) && len_ok;
    // Only the one-data-byte command passes the length check with length three.
    assign resp_len = (cmd == CMD_CODE_20);

    always_comb
    begin
        prev_pen_next = prev_pen_reg;
        skip_rem_next = skip_rem_reg;
        kind_next = KIND_UNKNOWN;
        data_next = '0;
        if (is_touch)
        begin
            if ((pen == prev_pen_reg) && (skip_rem_reg != 8'd0))
            begin
                skip_rem_next = skip_rem_reg - 8'd1;
                kind_next = KIND_SKIPPED;
            end
            else
            begin
                prev_pen_next = pen;
                skip_rem_next = skip_count_reg;
                kind_next = KIND_TOUCH;
                data_next[0] = pen;
                data_next[12:1] = pos_x;
                data_next[24:13] = pos_y;
                data_next[32:25] = pen ? PRESSURE_DOWN : 8'h00;
            end
        end
        else if (is_resp)
        begin
            if (resp_good)
            begin
                kind_next = KIND_RESP_OK;
                data_next[40:33] = b3;
                data_next[41] = resp_len;
                data_next[49:42] = resp_len ? b4 : 8'h00;
            end
            else
            begin
                kind_next = KIND_RESP_ERR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_count_reg <= 8'd0;
            prev_pen_reg <= 1'b0;
            skip_rem_reg <= 8'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                skip_count_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                prev_pen_reg <= prev_pen_next;
                skip_rem_reg <= skip_rem_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind_next;
            data_reg <= data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser = kind_reg;
    assign m_axis_tdata = data_reg;

endmodule

// ===== src/tfd_checker.sv =====
// Port-level checks for the touch frame decoder, bound to the top level.
module tfd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [tfd_pkg::OutDataWidth-1:0] m_axis_tdata,
    input tfd_pkg::kind_t                m_axis_tuser
);
    import tfd_pkg::*;

    // Every accepted frame shows a result beat in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted frame produced no result beat");

    // Touch fields are zero unless the beat is a touch report.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_TOUCH) |-> (m_axis_tdata[32:0] == '0))
        else $error("touch fields set on a non-touch result");

    // Pressure follows the pen bit on a touch report.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_TOUCH) |->
            (m_axis_tdata[32:25] == (m_axis_tdata[0] ? PRESSURE_DOWN : 8'h00)))
        else $error("pressure does not match pen bit");

    // Response data is zero unless the response was good and carries a data byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser != KIND_RESP_OK) || !m_axis_tdata[41]) |->
            (m_axis_tdata[49:42] == 8'h00))
        else $error("response data set without a good one-byte response");

    // Padding above the used fields stays zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OutDataWidth-1:OutUsedWidth] == '0))
        else $error("tdata padding bits not zero");

endmodule

bind touch_frame_decoder tfd_checker u_tfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/tb_touch_frame_decoder.sv =====
// Self-checking testbench for touch_frame_decoder: stream traffic, skip settings and output stalls.
`timescale 1ns / 100ps

module tb_touch_frame_decoder;
    import tfd_pkg::*;

    typedef struct packed {
        logic       pending;
        logic [7:0] cmd;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
    } frame_t;

    typedef struct packed {
        kind_t      kind;
        logic       pen;
        coord_t     x;
        coord_t     y;
        logic [7:0] pressure;
        logic [7:0] resp_cmd;
        logic       resp_len;
        logic [7:0] resp_data;
    } decoded_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [7:0]              cfg_wr_data;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    // expected_command, frame_byte0, frame_byte1, frame_byte2, frame_byte3, frame_byte4
    logic [47:0]             s_axis_tdata;
    // command_pending
    logic [0:0]              s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    // pen_contact, position_x, position_y, pressure, response_command,
    // response_length, response_data, zero fill
    logic [OutDataWidth-1:0] m_axis_tdata;
    // result_kind
    kind_t                   m_axis_tuser;

    touch_frame_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    decoded_t   decoded_queue[$];
    logic [7:0] skip_setting;
    logic       last_pen;
    logic [7:0] skips_left;
    logic       random_pen;
    int         mismatches = 0;
    bit         tx_idle;
    bit         rx_idle;
    bit         hold_request;
    int         hold_cycles;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #1ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Decodes one frame and advances the pen and skip state exactly as the block does.
    function automatic decoded_t decode_frame(input frame_t f);
        decoded_t r;
        logic     ok;
        r = '0;
        if (!f.pending && f.b0[7])
        begin
            if (f.b0[0] != last_pen)
                last_pen = f.b0[0];
            else if (skips_left != 8'd0)
            begin
                skips_left = skips_left - 8'd1;
                r.kind = KIND_SKIPPED;
                return r;
            end
            skips_left = skip_setting;
            r.kind = KIND_TOUCH;
            r.pen = f.b0[0];
            r.x = {f.b2[4:0], f.b1[6:0]};
            r.y = {f.b4[4:0], f.b3[6:0]};
            r.pressure = f.b0[0] ? PRESSURE_DOWN : 8'h00;
        end
        else if (f.pending && f.b0 == HDR_RESPONSE)
        begin
            ok = (f.b2 == 8'h00) && (f.b3 == f.cmd);
            case (f.cmd)
                CMD_CODE_12, CMD_CODE_13, CMD_CODE_21: ok = ok && (f.b1 == RESP_LEN_NO_DATA);
                CMD_CODE_20: ok = ok && (f.b1 == RESP_LEN_ONE_BYTE);
                default: ok = 1'b0;
            endcase
            if (ok)
            begin
                r.kind = KIND_RESP_OK;
                r.resp_cmd = f.b3;
                r.resp_len = (f.b1 == RESP_LEN_ONE_BYTE);
                r.resp_data = r.resp_len ? f.b4 : 8'h00;
            end
            else
                r.kind = KIND_RESP_ERR;
        end
        else
            r.kind = KIND_UNKNOWN;
        return r;
    endfunction

    function automatic string describe(input decoded_t d);
        return $sformatf("kind=%0d pen=%0b x=%0d y=%0d pressure=%0d cmd=%h len=%0b data=%h",
                         d.kind, d.pen, d.x, d.y, d.pressure, d.resp_cmd, d.resp_len, d.resp_data);
    endfunction

    // Junk mode sets every bit that the decoder must ignore.
    function automatic frame_t touch_frame(input logic pen, input coord_t x, input coord_t y,
                                           input logic junk);
        frame_t f;
        f.pending = 1'b0;
        f.cmd = junk ? 8'hFF : 8'h00;
        f.b0 = {1'b1, junk ? 6'h3F : 6'h00, pen};
        f.b1 = {junk, x[6:0]};
        f.b2 = {junk ? 3'b111 : 3'b000, x[11:7]};
        f.b3 = {junk, y[6:0]};
        f.b4 = {junk ? 3'b111 : 3'b000, y[11:7]};
        return f;
    endfunction

    function automatic frame_t response_frame(input logic [7:0] cmd, input logic [7:0] len,
                                              input logic [7:0] status, input logic [7:0] echo,
                                              input logic [7:0] data);
        frame_t f;
        f.pending = 1'b1;
        f.cmd = cmd;
        f.b0 = HDR_RESPONSE;
        f.b1 = len;
        f.b2 = status;
        f.b3 = echo;
        f.b4 = data;
        return f;
    endfunction

    // Mostly well-formed touch runs and command responses, the rest random noise.
    function automatic frame_t random_frame();
        frame_t f;
        int     pick;
        f.pending = 1'b0;
        f.cmd = 8'($urandom_range(0, 255));
        f.b0 = 8'($urandom_range(0, 255));
        f.b1 = 8'($urandom_range(0, 255));
        f.b2 = 8'($urandom_range(0, 255));
        f.b3 = 8'($urandom_range(0, 255));
        f.b4 = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            if ($urandom_range(0, 4) == 0)
                random_pen = ~random_pen;
            f.b0[7] = 1'b1;
            f.b0[0] = random_pen;
        end
        else if (pick < 80)
        begin
            f.pending = 1'b1;
            if ($urandom_range(0, 4) != 0)
            begin
                case ($urandom_range(0, 3))
                    0: f.cmd = CMD_CODE_12;
                    1: f.cmd = CMD_CODE_13;
                    2: f.cmd = CMD_CODE_20;
                    default: f.cmd = CMD_CODE_21;
                endcase
            end
            f.b0 = HDR_RESPONSE;
            if ($urandom_range(0, 6) != 0)
                f.b2 = 8'h00;
            if ($urandom_range(0, 6) != 0)
                f.b3 = f.cmd;
            if ($urandom_range(0, 4) != 0)
                f.b1 = (f.cmd == CMD_CODE_20) ? RESP_LEN_ONE_BYTE : RESP_LEN_NO_DATA;
            else if ($urandom_range(0, 1) != 0)
                f.b1 = 8'($urandom_range(RESP_LEN_NO_DATA, RESP_LEN_ONE_BYTE));
        end
        else
            f.pending = 1'($urandom_range(0, 1));
        return f;
    endfunction

    // Leaves tvalid high after the beat so that a back-to-back frame keeps it high.
    task automatic send_frame(input frame_t f);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {f.b4, f.b3, f.b2, f.b1, f.b0, f.cmd};
        s_axis_tuser <= f.pending;
        do @(posedge clk); while (!s_axis_tready);
        decoded_queue.push_back(decode_frame(f));
    endtask

    task automatic wait_for_results();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (decoded_queue.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_skip(input logic [7:0] value);
        wait_for_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        skip_setting = value;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_touch_extremes();
        send_frame(touch_frame(1'b1, 12'hFFF, 12'hFFF, 1'b1));
        send_frame(touch_frame(1'b0, 12'h000, 12'h000, 1'b1));
        send_frame(touch_frame(1'b0, 12'hFFF, 12'h000, 1'b0));
        send_frame(touch_frame(1'b1, 12'h000, 12'hFFF, 1'b0));
    endtask

    task automatic test_response_checks();
        send_frame(response_frame(CMD_CODE_12, RESP_LEN_NO_DATA, 8'h00, CMD_CODE_12, 8'hFF));
        send_frame(response_frame(CMD_CODE_13, RESP_LEN_NO_DATA, 8'h00, CMD_CODE_13, 8'h5A));
        send_frame(response_frame(CMD_CODE_21, RESP_LEN_NO_DATA, 8'h00, CMD_CODE_21, 8'h00));
        send_frame(response_frame(CMD_CODE_20, RESP_LEN_ONE_BYTE, 8'h00, CMD_CODE_20, 8'hFF));
        send_frame(response_frame(CMD_CODE_20, RESP_LEN_ONE_BYTE, 8'h00, CMD_CODE_20, 8'h00));
        // Each of these breaks one check: length, status, echo, unknown code.
        send_frame(response_frame(CMD_CODE_20, RESP_LEN_NO_DATA, 8'h00, CMD_CODE_20, 8'h11));
        send_frame(response_frame(CMD_CODE_12, RESP_LEN_ONE_BYTE, 8'h00, CMD_CODE_12, 8'h22));
        send_frame(response_frame(CMD_CODE_12, RESP_LEN_NO_DATA, 8'h80, CMD_CODE_12, 8'h33));
        send_frame(response_frame(CMD_CODE_13, RESP_LEN_NO_DATA, 8'h00, CMD_CODE_12, 8'h44));
        send_frame(response_frame(8'hFF, RESP_LEN_NO_DATA, 8'h00, 8'hFF, 8'h55));
    endtask

    task automatic test_unknown_headers();
        frame_t f;
        f = touch_frame(1'b0, 12'h5A5, 12'hA5A, 1'b1);
        f.b0 = 8'h7F;
        send_frame(f);
        f.b0 = HDR_RESPONSE;
        send_frame(f);
        f = response_frame(CMD_CODE_12, RESP_LEN_NO_DATA, 8'h00, CMD_CODE_12, 8'h00);
        f.b0 = 8'h81;
        send_frame(f);
        f.b0 = 8'h54;
        send_frame(f);
    endtask

    task automatic test_skip_thinning();
        write_skip(8'd2);
        send_frame(touch_frame(1'b1, 12'd100, 12'd200, 1'b0));
        send_frame(touch_frame(1'b1, 12'd101, 12'd201, 1'b0));
        send_frame(touch_frame(1'b1, 12'd102, 12'd202, 1'b0));
        send_frame(touch_frame(1'b1, 12'd103, 12'd203, 1'b0));
        send_frame(touch_frame(1'b1, 12'd104, 12'd204, 1'b0));
        // A pen lift in the middle of a skip run must still be reported.
        send_frame(touch_frame(1'b0, 12'd105, 12'd205, 1'b0));
        send_frame(touch_frame(1'b0, 12'd106, 12'd206, 1'b0));
        send_frame(touch_frame(1'b1, 12'd107, 12'd207, 1'b0));
    endtask

    task automatic test_random_traffic(input int count, input logic [7:0] skip,
                                       input bit tx_gaps, input bit rx_gaps);
        write_skip(skip);
        tx_idle = tx_gaps;
        rx_idle = rx_gaps;
        repeat (count) send_frame(random_frame());
    endtask

    task automatic test_output_backpressure();
        wait_for_results();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        hold_cycles = 300;
        hold_request = 1'b1;
        repeat (48) send_frame(random_frame());
    endtask

    // Receiver side: random stalls per beat, plus one long hold-off on request.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
            end
            stall = rx_idle ? $urandom_range(0, 11) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin : check_results
        decoded_t seen;
        decoded_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.kind = m_axis_tuser;
            seen.pen = m_axis_tdata[0];
            seen.x = m_axis_tdata[12:1];
            seen.y = m_axis_tdata[24:13];
            seen.pressure = m_axis_tdata[32:25];
            seen.resp_cmd = m_axis_tdata[40:33];
            seen.resp_len = m_axis_tdata[41];
            seen.resp_data = m_axis_tdata[49:42];
            if (decoded_queue.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: result beat with nothing expected: %s", $realtime,
                             describe(seen));
                mismatches++;
            end
            else
            begin
                want = decoded_queue.pop_front();
                if (seen !== want || m_axis_tdata[OutDataWidth-1:OutUsedWidth] !== '0)
                begin
                    if (mismatches < 10)
                        $display("%0t: mismatch\n  expected %s\n  actual   %s fill=%h", $realtime,
                                 describe(want), describe(seen),
                                 m_axis_tdata[OutDataWidth-1:OutUsedWidth]);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 8'h00;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        skip_setting = 8'd0;
        last_pen = 1'b0;
        skips_left = 8'd0;
        random_pen = 1'b0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        hold_request = 1'b0;
        hold_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_touch_extremes();
        test_response_checks();
        test_unknown_headers();
        test_skip_thinning();
        test_random_traffic(200, 8'd0, 1'b1, 1'b1);
        test_random_traffic(180, 8'd1, 1'b0, 1'b0);
        test_output_backpressure();
        test_random_traffic(180, 8'd3, 1'b1, 1'b0);
        test_random_traffic(160, 8'd255, 1'b0, 1'b1);
        test_random_traffic(160, 8'($urandom_range(0, 255)), 1'b1, 1'b1);
        wait_for_results();

        if (mismatches == 0 && decoded_queue.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
